// ===== src/tt_pkg.sv =====
// Shared types, widths and codes of the trickle timer.
package tt_pkg;

  localparam int unsigned OP_W     = 2;
  localparam int unsigned RAND_W   = 32;
  localparam int unsigned MS_W     = 24;
  localparam int unsigned K_W      = 8;
  localparam int unsigned TIME_W   = 48;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 24;
  localparam int unsigned DIV_CNT_W = 5;

  localparam logic [MS_W-1:0] IMIN_RST = MS_W'(200);
  localparam logic [MS_W-1:0] IMAX_RST = MS_W'(40000);
  localparam logic [K_W-1:0]  K_RST    = K_W'(1);
  localparam logic [MS_W-1:0] GAP_RST  = '0;

  typedef enum logic [OP_W-1:0] {
    OP_TICK  = 2'd0,
    OP_RESET = 2'd1,
    OP_HEARD = 2'd2
  } op_e;

  localparam logic [CFG_IDX_W-1:0] CFG_IMIN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAX = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_K    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_GAP  = 2'd3;

  typedef struct packed {
    logic capture;
    logic eval;
    logic decide;
    logic clamp;
    logic div_step;
    logic offs;
    logic fin;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] in_op;
    logic            end_due;
    logic            send_due;
    logic            half_zero;
    logic            div_last;
  } dp_stat_t;

endpackage

// ===== src/tt_if.sv =====
// Request channels of the trickle timer: items, results and register writes.
interface tt_in_if;
  import tt_pkg::*;
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   op;
  logic [RAND_W-1:0] rand_value;
  modport source (output valid, op, rand_value, input ready);
  modport sink   (input valid, op, rand_value, output ready);
endinterface

interface tt_out_if;
  import tt_pkg::*;
  logic            valid;
  logic            ready;
  logic            sent;
  logic            skipped;
  logic            new_interval;
  logic [MS_W-1:0] interval_ms;
  logic [K_W-1:0]  heard_count;
  modport source (output valid, sent, skipped, new_interval, interval_ms, heard_count,
                  input ready);
  modport sink   (input valid, sent, skipped, new_interval, interval_ms, heard_count,
                  output ready);
endinterface

interface tt_cfg_if;
  import tt_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== src/tt_ctrl.sv =====
// Sequencer of the trickle timer: steps the datapath through one request.
module tt_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  input  tt_pkg::dp_stat_t stat_i,
  output tt_pkg::dp_cmd_t  cmd_o
);
  import tt_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_EVAL   = 3'd1;
  localparam logic [2:0] S_DECIDE = 3'd2;
  localparam logic [2:0] S_CLAMP  = 3'd3;
  localparam logic [2:0] S_DIV    = 3'd4;
  localparam logic [2:0] S_OFFS   = 3'd5;
  localparam logic [2:0] S_FIN    = 3'd6;
  localparam logic [2:0] S_DONE   = 3'd7;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;

  always_comb begin
    cmd_o       = '0;
    state_d     = state_q;
    out_valid_d = out_valid_q;
    in_ready_o  = 1'b0;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          case (stat_i.in_op)
            OP_TICK:  state_d = S_EVAL;
            OP_RESET: state_d = S_CLAMP;
            default:  state_d = S_DONE;
          endcase
        end
      end
      S_EVAL: begin
        cmd_o.eval = 1'b1;
        state_d    = S_DECIDE;
      end
      S_DECIDE: begin
        // An ending interval takes precedence and drops any pending send.
        if (stat_i.end_due) begin
          state_d = S_CLAMP;
        end else begin
          cmd_o.decide = stat_i.send_due;
          state_d      = S_DONE;
        end
      end
      S_CLAMP: begin
        cmd_o.clamp = 1'b1;
        state_d     = S_DIV;
      end
      S_DIV: begin
        if (stat_i.half_zero) begin
          state_d = S_OFFS;
        end else begin
          cmd_o.div_step = 1'b1;
          if (stat_i.div_last) begin
            state_d = S_OFFS;
          end
        end
      end
      S_OFFS: begin
        cmd_o.offs = 1'b1;
        state_d    = S_FIN;
      end
      S_FIN: begin
        cmd_o.fin = 1'b1;
        state_d   = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== src/tt_datapath.sv =====
// Timer state, registers, bit-serial modulo unit and result register.
module tt_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  tt_pkg::dp_cmd_t               cmd_i,
  output tt_pkg::dp_stat_t              stat_o,
  input  logic [tt_pkg::OP_W-1:0]       in_op_i,
  input  logic [tt_pkg::RAND_W-1:0]     in_rand_i,
  input  logic                          cfg_we_i,
  input  logic [tt_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [tt_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output logic                          sent_o,
  output logic                          skipped_o,
  output logic                          new_interval_o,
  output logic [tt_pkg::MS_W-1:0]       interval_ms_o,
  output logic [tt_pkg::K_W-1:0]        heard_count_o
);
  import tt_pkg::*;

  // Configuration registers.
  logic [MS_W-1:0] imin_q, imax_q, gap_q;
  logic [K_W-1:0]  k_q;

  // Timer state.
  logic [TIME_W-1:0] time_q, send_at_q, end_q, last_q;
  logic [MS_W-1:0]   len_q;
  logic [K_W-1:0]    cnt_q;

  // Per-request working registers.
  logic [OP_W-1:0]      op_q;
  logic [RAND_W-1:0]    rnd_q;
  logic                 end_due_q, send_due_q, gap_ok_q;
  logic [MS_W-1:0]      i_q, rem_q, offs_q;
  logic [DIV_CNT_W-1:0] dcnt_q;
  logic                 sent_q, skip_q, fresh_q;

  // Result register.
  logic            out_sent_q, out_skip_q, out_fresh_q;
  logic [MS_W-1:0] out_len_q;
  logic [K_W-1:0]  out_cnt_q;

  logic [MS_W:0]     want;
  logic [MS_W-1:0]   clamped;
  logic [MS_W-2:0]   half;
  logic [MS_W:0]     trial;
  logic [MS_W:0]     trial_sub;
  logic [TIME_W:0]   gap_end;

  assign half = i_q[MS_W-1:1];

  always_comb begin
    want = (op_q == OP_TICK) ? {len_q, 1'b0} : {1'b0, imin_q};
    if (want < {1'b0, imin_q}) begin
      clamped = imin_q;
    end else if (want > {1'b0, imax_q}) begin
      clamped = imax_q;
    end else begin
      clamped = want[MS_W-1:0];
    end
  end

  // One restoring step: shift in the next dividend bit, subtract when it fits.
  assign trial     = {rem_q, rnd_q[RAND_W-1]};
  assign trial_sub = trial - {2'b00, half};
  assign gap_end   = {1'b0, last_q} + {{(TIME_W-MS_W+1){1'b0}}, gap_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      imin_q <= IMIN_RST;
      imax_q <= IMAX_RST;
      k_q    <= K_RST;
      gap_q  <= GAP_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_IMIN: imin_q <= cfg_data_i[MS_W-1:0];
        CFG_IMAX: imax_q <= cfg_data_i[MS_W-1:0];
        CFG_K:    k_q    <= cfg_data_i[K_W-1:0];
        CFG_GAP:  gap_q  <= cfg_data_i[MS_W-1:0];
        default:  ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      time_q    <= '0;
      len_q     <= '0;
      send_at_q <= '0;
      end_q     <= '0;
      cnt_q     <= '0;
      last_q    <= '0;
    end else begin
      if (cmd_i.capture) begin
        if (in_op_i == OP_TICK) begin
          time_q <= time_q + TIME_W'(1);
        end
        if (in_op_i == OP_HEARD && cnt_q != '1) begin
          cnt_q <= cnt_q + K_W'(1);
        end
      end
      if (cmd_i.decide) begin
        send_at_q <= '0;
        if (cnt_q < k_q || gap_ok_q) begin
          last_q <= time_q;
        end
      end
      if (cmd_i.fin) begin
        len_q     <= i_q;
        send_at_q <= time_q + {{(TIME_W-MS_W){1'b0}}, offs_q};
        end_q     <= time_q + {{(TIME_W-MS_W){1'b0}}, i_q};
        cnt_q     <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q    <= in_op_i;
      rnd_q   <= in_rand_i;
      sent_q  <= 1'b0;
      skip_q  <= 1'b0;
      fresh_q <= 1'b0;
    end
    if (cmd_i.eval) begin
      end_due_q  <= end_q <= time_q;
      send_due_q <= (send_at_q != '0) && (send_at_q <= time_q);
      gap_ok_q   <= (gap_q != '0) && (gap_end <= {1'b0, time_q});
    end
    if (cmd_i.decide) begin
      sent_q <= (cnt_q < k_q) || gap_ok_q;
      skip_q <= !((cnt_q < k_q) || gap_ok_q);
    end
    if (cmd_i.clamp) begin
      i_q    <= clamped;
      rem_q  <= '0;
      dcnt_q <= DIV_CNT_W'(RAND_W - 1);
    end
    if (cmd_i.div_step) begin
      rnd_q  <= {rnd_q[RAND_W-2:0], 1'b0};
      dcnt_q <= dcnt_q - DIV_CNT_W'(1);
      if (!trial_sub[MS_W]) begin
        rem_q <= trial_sub[MS_W-1:0];
      end else begin
        rem_q <= trial[MS_W-1:0];
      end
    end
    if (cmd_i.offs) begin
      offs_q <= {1'b0, half} + rem_q;
    end
    if (cmd_i.fin) begin
      fresh_q <= 1'b1;
    end
    if (cmd_i.out_load) begin
      out_sent_q  <= sent_q;
      out_skip_q  <= skip_q;
      out_fresh_q <= fresh_q;
      out_len_q   <= len_q;
      out_cnt_q   <= cnt_q;
    end
  end

  assign stat_o.in_op     = in_op_i;
  assign stat_o.end_due   = end_due_q;
  assign stat_o.send_due  = send_due_q;
  assign stat_o.half_zero = (half == '0);
  assign stat_o.div_last  = (dcnt_q == '0);

  assign sent_o         = out_sent_q;
  assign skipped_o      = out_skip_q;
  assign new_interval_o = out_fresh_q;
  assign interval_ms_o  = out_len_q;
  assign heard_count_o  = out_cnt_q;

endmodule

// ===== src/trickle_timer_unit.sv =====
// Top level of the trickle timer: sequencer and datapath.
//
//   channel | direction | payload
//   in_i    | sink      | op, rand_value
//   out_o   | source    | sent, skipped, new_interval, interval_ms, heard_count
//   cfg_i   | sink      | index, data (always ready)
//
// A heard or unused request goes from capture straight to the result state, a
// tick without a new interval first evaluates and decides, and one that starts
// an interval also clamps it, runs the 32-step bit-serial modulo of rand_value
// by half the interval (skipped if half is zero) and sets the send offset. One
// request is worked on at a time; the next is accepted once its predecessor's
// result sits in the output register, even if that result is still stalled.
// Reset clears the timer state and loads the register defaults at once.
module trickle_timer_unit (
  input logic        clk_i,
  input logic        rst_ni,
  tt_in_if.sink      in_i,
  tt_out_if.source   out_o,
  tt_cfg_if.sink     cfg_i
);
  import tt_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  assign cfg_i.ready = 1'b1;

  tt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  tt_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .in_op_i        (in_i.op),
    .in_rand_i      (in_i.rand_value),
    .cfg_we_i       (cfg_i.valid),
    .cfg_idx_i      (cfg_i.index),
    .cfg_data_i     (cfg_i.data),
    .sent_o         (out_o.sent),
    .skipped_o      (out_o.skipped),
    .new_interval_o (out_o.new_interval),
    .interval_ms_o  (out_o.interval_ms),
    .heard_count_o  (out_o.heard_count)
  );

endmodule

// ===== src/tt_checker.sv =====
// Port-level assertions of the trickle timer and their bind.
module tt_checker (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    in_valid_i,
  input logic                    in_ready_i,
  input logic                    out_valid_i,
  input logic                    out_ready_i,
  input logic                    sent_i,
  input logic                    skipped_i,
  input logic                    new_interval_i,
  input logic [tt_pkg::K_W-1:0]  heard_count_i
);
  import tt_pkg::*;

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result withdrawn while stalled");

  // A request is never followed by another in the very next cycle.
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("request accepted while previous one in progress");

  // Sending, skipping and starting an interval exclude one another.
  a_flags_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> !(sent_i && skipped_i) && !(new_interval_i && (sent_i || skipped_i)))
    else $error("conflicting result flags");

  // A fresh interval starts with an empty heard count.
  a_fresh_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && new_interval_i |-> heard_count_i == '0)
    else $error("heard count not cleared on new interval");

endmodule

bind trickle_timer_unit tt_checker u_tt_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_i.valid),
  .in_ready_i     (in_i.ready),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .sent_i         (out_o.sent),
  .skipped_i      (out_o.skipped),
  .new_interval_i (out_o.new_interval),
  .heard_count_i  (out_o.heard_count)
);
